// ----- rtl/dds_waveform_generator_assert.svh -----
// ----------------------------------------------------------------------------
// DDS waveform generator assertion macros
// Concurrent checks that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef DDS_WAVEFORM_GENERATOR_ASSERT_SVH
`define DDS_WAVEFORM_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, suspended while reset is high.
`define DDS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define DDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DDS_ASSERT(lbl, clk, rst, prop, msg)
`define DDS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/dds_pkg.sv -----
// ----------------------------------------------------------------------------
// DDS package
// Widths, register and waveform codes, and the sine lookup table.
// ----------------------------------------------------------------------------
package dds_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 8;
  localparam int TUNING_BITS     = 32;
  localparam int SUM_BITS        = (PHASE_BITS > TUNING_BITS) ? PHASE_BITS : TUNING_BITS;
  localparam int BYTE_SHIFT      = PHASE_BITS - TABLE_ADDR_BITS;
  localparam int SAMPLE_BITS     = 12;
  localparam int TABLE_BITS      = 8;
  localparam int WAVE_BITS       = 2;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 32;
  localparam int S_TDATA_BITS    = 8;
  localparam int M_TDATA_BITS    = 16;

  localparam logic [TUNING_BITS-1:0] TUNING_RESET = TUNING_BITS'(42950);

  // Register indexes on the configuration channel
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TUNING_WORD = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WAVE_SELECT = CFG_INDEX_BITS'(1);

  // Waveform codes; the unused code falls back to sine
  localparam logic [WAVE_BITS-1:0] WAVE_SINE   = WAVE_BITS'(0);
  localparam logic [WAVE_BITS-1:0] WAVE_SQUARE = WAVE_BITS'(1);
  localparam logic [WAVE_BITS-1:0] WAVE_RAMP   = WAVE_BITS'(2);

  localparam logic [SAMPLE_BITS-1:0]     SAMPLE_MAX  = SAMPLE_BITS'(4095);
  localparam logic [TABLE_ADDR_BITS-1:0] SQUARE_HALF = TABLE_ADDR_BITS'(127);

  // byte*4095/255 = 16*byte + byte/17; byte/17 = (byte*241) >> 12 for byte < 256
  localparam int RAMP_RECIP_BITS = 8;
  localparam logic [RAMP_RECIP_BITS-1:0] RAMP_RECIP = RAMP_RECIP_BITS'(241);
  localparam int RAMP_SHIFT = 12;
  localparam int RAMP_PROD_BITS = TABLE_ADDR_BITS + RAMP_RECIP_BITS;

  typedef struct packed {
    logic [TUNING_BITS-1:0] phase_step;
    logic [WAVE_BITS-1:0]   wave_select;
  } cfg_t;

  localparam logic [TABLE_BITS-1:0] SINE_TABLE [256] = '{
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
    8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185,
    8'd188, 8'd190, 8'd193, 8'd196, 8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211,
    8'd213, 8'd215, 8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244, 8'd245, 8'd246,
    8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254,
    8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254,
    8'd254, 8'd253, 8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
    8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235, 8'd234, 8'd232,
    8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220, 8'd218, 8'd215, 8'd213, 8'd211,
    8'd208, 8'd206, 8'd203, 8'd201, 8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185,
    8'd182, 8'd179, 8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131, 8'd128, 8'd124,
    8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106, 8'd103, 8'd100, 8'd97,  8'd93,
    8'd90,  8'd88,  8'd85,  8'd82,  8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,
    8'd62,  8'd59,  8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
    8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,  8'd21,  8'd20,
    8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,  8'd10,  8'd9,   8'd7,   8'd6,
    8'd5,   8'd5,   8'd4,   8'd3,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,   8'd10,  8'd11,
    8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,  8'd21,  8'd23,  8'd25,  8'd27,
    8'd29,  8'd31,  8'd33,  8'd35,  8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,
    8'd52,  8'd54,  8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
    8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100, 8'd103, 8'd106,
    8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
  };

endpackage

// ----- rtl/dds_waveform_generator.sv -----
// ----------------------------------------------------------------------------
// DDS waveform generator
// Numerically controlled oscillator for a 12-bit converter. Every item on the
// input stream requests one sample; bit 0 of its tdata clears the phase for
// that sample first. The top byte of a 32-bit phase accumulator picks the
// output from a 256-entry sine table (scaled by 16), a square wave (4095 in
// the upper half of the cycle, else 0) or a rising ramp (byte*4095/255), as
// chosen by wave_select; the phase step is then added to the phase, so the
// output frequency is the phase step / 2^32 of the item rate. The block takes
// one item per clock while the output stream is not stalled: the phase
// register and its one adder close the feedback loop. A taken item is held in
// the lookup stage register, then moves into the output register, which
// presents its result on the output stream; each stage advances when the
// stage after it is empty or being drained.
// Registers sit on the configuration channel: index 0 phase step (reset
// 42950), index 1 wave_select (reset 0; 0 sine, 1 square, 2 ramp, 3 sine).
// cfg_ready is always high; write registers only while no item is in flight.
// ----------------------------------------------------------------------------
`include "dds_waveform_generator_assert.svh"

module dds_waveform_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  // Sample requests
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [dds_pkg::S_TDATA_BITS-1:0]      s_axis_tdata,   // [0] clear_phase
  // Samples
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [dds_pkg::M_TDATA_BITS-1:0]      m_axis_tdata,   // [11:0] sample
  // Configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dds_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [dds_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import dds_pkg::*;

  cfg_t                       cfg;
  logic                       accept;
  logic [TABLE_ADDR_BITS-1:0] phase_byte;

  // Lookup stage: phase byte and waveform of the item in flight
  logic                       s1_valid;
  logic                       s1_ready;
  logic [TABLE_ADDR_BITS-1:0] s1_byte;
  logic [WAVE_BITS-1:0]       s1_wave;
  logic [SAMPLE_BITS-1:0]     s1_sample;

  // Output register
  logic [SAMPLE_BITS-1:0]     out_sample;
  logic [WAVE_BITS-1:0]       out_wave;

  dds_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dds_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .clear_phase (s_axis_tdata[0]),
    .phase_step  (cfg.phase_step),
    .phase_byte  (phase_byte)
  );

  dds_shape u_shape (
    .phase_byte  (s1_byte),
    .wave_select (s1_wave),
    .sample      (s1_sample)
  );

  // Each stage advances when the stage after it is empty or being drained
  assign s1_ready      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || s1_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_ready) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload: lookup stage captures on accept, output register when the lookup stage moves on; both hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= phase_byte;
      s1_wave <= cfg.wave_select;
    end
    if (s1_valid && s1_ready) begin
      out_sample <= s1_sample;
      out_wave   <= s1_wave;
    end
  end

  assign m_axis_tdata = {(M_TDATA_BITS - SAMPLE_BITS)'(0), out_sample};

  `DDS_ASSERT(a_square_levels, clk, rst, (m_axis_tvalid && out_wave == WAVE_SQUARE) |-> (out_sample == '0 || out_sample == SAMPLE_MAX), "square sample off its two levels")
  `DDS_ASSERT(a_sine_scaled, clk, rst, (m_axis_tvalid && out_wave != WAVE_SQUARE && out_wave != WAVE_RAMP) |-> (out_sample[3:0] == 4'b0000), "sine sample not a multiple of 16")
  `DDS_ASSERT(a_s1_hold, clk, rst, (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_byte) && $stable(s1_wave)), "lookup stage lost a stalled item")

endmodule

// ----- rtl/dds_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// DDS configuration registers
// Phase step and waveform select, written over the configuration channel.
// ----------------------------------------------------------------------------
module dds_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dds_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [dds_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output dds_pkg::cfg_t                         cfg
);
  import dds_pkg::*;

  logic write;

  assign cfg_ready = 1'b1;
  assign write     = cfg_valid && cfg_ready;

  // Writes to indexes beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step  <= TUNING_RESET;
      cfg.wave_select <= WAVE_SINE;
    end else if (write) begin
      case (cfg_index)
        CFG_TUNING_WORD: cfg.phase_step  <= cfg_data[TUNING_BITS-1:0];
        CFG_WAVE_SELECT: cfg.wave_select <= cfg_data[WAVE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/dds_phase.sv -----
// ----------------------------------------------------------------------------
// DDS phase accumulator
// Presents the table address for the current item and advances the phase.
// ----------------------------------------------------------------------------
`include "dds_waveform_generator_assert.svh"

module dds_phase (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  logic                                  clear_phase,
  input  logic [dds_pkg::TUNING_BITS-1:0]       phase_step,
  output logic [dds_pkg::TABLE_ADDR_BITS-1:0]   phase_byte
);
  import dds_pkg::*;

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_next;
  logic [PHASE_BITS-1:0] base;
  logic [SUM_BITS-1:0]   sum;

  // A clear restarts both the lookup and the addition from zero
  assign base       = clear_phase ? '0 : phase;
  assign phase_byte = base[BYTE_SHIFT +: TABLE_ADDR_BITS];
  assign sum        = SUM_BITS'(base) + SUM_BITS'(phase_step);
  assign phase_next = sum[PHASE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  `DDS_ASSERT_ALWAYS(a_phase_reset, clk, rst |=> (phase == '0), "phase not zero after reset")
  `DDS_ASSERT(a_phase_hold, clk, rst, !advance |=> $stable(phase), "phase moved without an item")
  `DDS_ASSERT(a_phase_clear, clk, rst, (advance && clear_phase) |=> (phase == PHASE_BITS'(SUM_BITS'($past(phase_step)))), "cleared phase did not restart at the phase step")

endmodule

// ----- rtl/dds_shape.sv -----
// ----------------------------------------------------------------------------
// DDS waveform shaper
// Maps a phase byte to a 12-bit sample: sine table, square or ramp.
// ----------------------------------------------------------------------------
module dds_shape (
  input  logic [dds_pkg::TABLE_ADDR_BITS-1:0]   phase_byte,
  input  logic [dds_pkg::WAVE_BITS-1:0]         wave_select,
  output logic [dds_pkg::SAMPLE_BITS-1:0]       sample
);
  import dds_pkg::*;

  logic [RAMP_PROD_BITS-1:0]  ramp_prod;
  logic [SAMPLE_BITS-1:0]     ramp;
  logic [SAMPLE_BITS-1:0]     square;
  logic [SAMPLE_BITS-1:0]     sine;

  // Ramp: 16*byte plus byte/17 through a reciprocal multiply
  assign ramp_prod = RAMP_PROD_BITS'(phase_byte) * RAMP_PROD_BITS'(RAMP_RECIP);
  assign ramp      = {phase_byte, 4'b0000} + SAMPLE_BITS'(ramp_prod >> RAMP_SHIFT);
  assign square    = (phase_byte > SQUARE_HALF) ? SAMPLE_MAX : '0;
  assign sine      = {SINE_TABLE[phase_byte], 4'b0000};

  always_comb begin
    case (wave_select)
      WAVE_SQUARE: sample = square;
      WAVE_RAMP:   sample = ramp;
      default:     sample = sine;
    endcase
  end

endmodule
